FILE: src/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg - shared types and constants of the differential drive mixer
// Register indexes, reset values, reciprocal constants, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ddm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADZONE     = 3'd0,
    CFG_EXPO_PERCENT = 3'd1,
    CFG_MAX_PERMILLE = 3'd2,
    CFG_TIMEOUT_MS   = 3'd3,
    CFG_INVERT_LEFT  = 3'd4,
    CFG_INVERT_RIGHT = 3'd5
  } ddm_cfg_idx_e;

  localparam logic [6:0]  DEADZONE_RST     = 7'd5;
  localparam logic [6:0]  EXPO_RST         = 7'd0;
  localparam logic [9:0]  MAX_PERMILLE_RST = 10'd1000;
  localparam logic [15:0] TIMEOUT_RST      = 16'd200;

  localparam logic [6:0]  AXIS_FULL        = 7'd100;
  localparam logic [9:0]  PERMILLE_FULL    = 10'd1000;

  // floor(n/100) = (n * RECIP_100) >> 24, exact for n < 2^17
  localparam logic [17:0] RECIP_100        = 18'd167773;
  localparam int unsigned RECIP_100_SHIFT  = 24;
  // floor(n/10000) = (n * RECIP_10K) >> 34, exact for n < 2^20
  localparam logic [20:0] RECIP_10K        = 21'd1717987;
  localparam int unsigned RECIP_10K_SHIFT  = 34;

  // Shaping and mixing stages between the update request and the divider
  localparam logic [2:0]  SHAPE_CYCLES     = 3'd5;
  // Restoring divider: one quotient bit per cycle over the 17-bit dividend
  localparam int unsigned DivW             = 17;
  localparam logic [4:0]  DIV_STEPS        = 5'd17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_SCALE,
    ST_OUTPUT
  } ddm_state_e;

  typedef struct packed {
    logic store_cmd;
    logic check_timeout;
    logic div_start;
    logic load_out;
  } ddm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ddm_sts_t;

endpackage

FILE: src/differential_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer_unit - arcade-style differential drive mixer
// Stick commands are held with a timestamp; update requests give shaped,
// mixed and scaled left/right drive in permille, with command failsafe.
// ----------------------------------------------------------------------------
// Send stick command requests (tuser = 0) and update requests (tuser = 1) on
// the slave stream. A stick command is stored when accepted and gives no
// result; the block is ready again in the next cycle. An update runs through
// the controller from acceptance to a loaded result. The timeout check
// happens at the accepting edge itself. After that come the shaping and
// mixing stages and a state to start the divider, then the restoring divider
// (one quotient bit per cycle over the 17-bit scale dividend) and a state to
// see it finish. Last come the final multiply and reciprocal stages, where
// the load waits for a free output register. The controller returns to idle
// with the load, and only one update is in flight at a time. The result sits
// in an output register, so the next request is taken while an earlier
// result still waits on the master stream. Configuration must be written by
// the user through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is
// idle; the block does not enforce this. Indexes six and seven are
// ignored.
// ----------------------------------------------------------------------------
module differential_drive_mixer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [ddm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ddm_pkg::CfgDataW-1:0] cfg_data_i,
  // Request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // stick_x[15:0], stick_y[31:16],
                                                      // now_ms[63:32]
  input  logic                         s_axis_tuser,  // mode
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata   // left_drive[10:0], right_drive[21:11],
                                                      // shaped_x[29:22], shaped_y[37:30],
                                                      // failsafe[38], zero pad[39]
);
  import ddm_pkg::*;

  ddm_cmd_t           cmd;
  ddm_sts_t           sts;
  logic signed [10:0] left_drive, right_drive;
  logic signed [7:0]  shaped_x, shaped_y;
  logic               failsafe;

  // Controller: takes requests and steps the datapath through an update
  ddm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: configuration, held state, shaping lanes, divider, output
  ddm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .stick_x_i     ($signed(s_axis_tdata[15:0])),
    .stick_y_i     ($signed(s_axis_tdata[31:16])),
    .now_ms_i      (s_axis_tdata[63:32]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .left_drive_o  (left_drive),
    .right_drive_o (right_drive),
    .shaped_x_o    (shaped_x),
    .shaped_y_o    (shaped_y),
    .failsafe_o    (failsafe)
  );

  // Pack the result fields, lowest field in the lowest bits
  assign m_axis_tdata = {1'b0, failsafe, shaped_y, shaped_x, right_drive, left_drive};

  // An accepted update holds off further requests until it completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("request taken while an update was in progress");

  // A stick command leaves the block ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> s_axis_tready)
    else $error("stick command stalled the request stream");

  // A result under failsafe carries zero axes and zero drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && failsafe) |->
      (shaped_x == 8'sd0 && shaped_y == 8'sd0 &&
       left_drive == 11'sd0 && right_drive == 11'sd0))
    else $error("failsafe result with non-zero drive");

  // Drive stays within full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (left_drive <= 11'sd1000 && left_drive >= -11'sd1000 &&
       right_drive <= 11'sd1000 && right_drive >= -11'sd1000))
    else $error("drive beyond full scale");

endmodule

FILE: src/ddm_div.sv
// ----------------------------------------------------------------------------
// ddm_div - iterative restoring divider
// Produces one quotient bit per cycle; done is high once all bits are in.
// ----------------------------------------------------------------------------
module ddm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ddm_pkg::DivW-1:0] dividend_i,
  input  logic [7:0]               divisor_i,
  output logic [ddm_pkg::DivW-1:0] quotient_o,
  output logic                     done_o
);
  import ddm_pkg::*;

  logic [4:0]      cnt_q, cnt_d;
  logic [7:0]      rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [8:0]      trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    trial = {rem_q, quo_q[DivW-1]};
    if (start_i) begin
      cnt_d = DIV_STEPS;
      rem_d = 8'd0;
      quo_d = dividend_i;
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 8'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = (cnt_q == 5'd0);

endmodule

FILE: src/ddm_dp.sv
// ----------------------------------------------------------------------------
// ddm_dp - datapath of the differential drive mixer
// Configuration registers, held stick state, shaping lanes, mixer, scaling
// through the shared divider, and the output register.
// ----------------------------------------------------------------------------
module ddm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ddm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ddm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic signed [15:0]           stick_x_i,
  input  logic signed [15:0]           stick_y_i,
  input  logic [31:0]                  now_ms_i,
  input  ddm_pkg::ddm_cmd_t            cmd_i,
  output ddm_pkg::ddm_sts_t            sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [10:0]           left_drive_o,
  output logic signed [10:0]           right_drive_o,
  output logic signed [7:0]            shaped_x_o,
  output logic signed [7:0]            shaped_y_o,
  output logic                         failsafe_o
);
  import ddm_pkg::*;

  // Configuration
  logic [6:0]  deadzone_q, expo_q;
  logic [9:0]  max_pm_q;
  logic [15:0] timeout_q;
  logic        inv_left_q, inv_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q  <= DEADZONE_RST;
      expo_q      <= EXPO_RST;
      max_pm_q    <= MAX_PERMILLE_RST;
      timeout_q   <= TIMEOUT_RST;
      inv_left_q  <= 1'b0;
      inv_right_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADZONE:     deadzone_q  <= cfg_data_i[6:0];
        CFG_EXPO_PERCENT: expo_q      <= cfg_data_i[6:0];
        CFG_MAX_PERMILLE: max_pm_q    <= cfg_data_i[9:0];
        CFG_TIMEOUT_MS:   timeout_q   <= cfg_data_i;
        CFG_INVERT_LEFT:  inv_left_q  <= cfg_data_i[0];
        CFG_INVERT_RIGHT: inv_right_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [6:0] expo_eff;
  logic [9:0] lim_eff;
  assign expo_eff = (expo_q > AXIS_FULL) ? AXIS_FULL : expo_q;
  assign lim_eff  = (max_pm_q > PERMILLE_FULL) ? PERMILLE_FULL : max_pm_q;

  // Held stick and failsafe
  logic signed [7:0] held_x_q, held_y_q;
  logic [31:0]       last_cmd_q;
  logic              fs_q;
  logic [31:0]       age;
  logic              expired;

  function automatic logic signed [7:0] clamp_axis(input logic signed [15:0] v);
    logic signed [7:0] res;
    if (v > 16'sd100) begin
      res = 8'sd100;
    end else if (v < -16'sd100) begin
      res = -8'sd100;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  assign age     = now_ms_i - last_cmd_q;
  assign expired = age > {16'd0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q   <= 8'sd0;
      held_y_q   <= 8'sd0;
      last_cmd_q <= 32'd0;
      fs_q       <= 1'b1;
    end else if (cmd_i.store_cmd) begin
      held_x_q   <= clamp_axis(stick_x_i);
      held_y_q   <= clamp_axis(stick_y_i);
      last_cmd_q <= now_ms_i;
    end else if (cmd_i.check_timeout) begin
      if (expired) begin
        held_x_q <= 8'sd0;
        held_y_q <= 8'sd0;
        fs_q     <= 1'b1;
      end else begin
        fs_q     <= 1'b0;
      end
    end
  end

  // Shaping lanes: lane 0 turn axis, lane 1 throttle axis
  logic signed [7:0] axis_v [2];
  assign axis_v[0] = held_x_q;
  assign axis_v[1] = held_y_q;

  logic [7:0]  a_full   [2];
  logic [6:0]  a_mag    [2];
  logic [13:0] sa_t1_d  [2];
  logic [13:0] sa_p_d   [2];
  logic [13:0] sa_t1_q  [2];
  logic [13:0] sa_p_q   [2];
  logic        sa_neg_q [2];
  logic        sa_zero_q[2];

  logic [31:0] sb_lin_prod [2];
  logic [31:0] sb_lin_sh   [2];
  logic [6:0]  sb_lin_q    [2];
  logic [19:0] sb_pe_q     [2];
  logic        sb_neg_q    [2];
  logic        sb_zero_q   [2];

  logic [40:0] sc_sq_prod [2];
  logic [40:0] sc_sq_sh   [2];
  logic [6:0]  sc_lin_q   [2];
  logic [6:0]  sc_sq_q    [2];
  logic        sc_neg_q   [2];
  logic        sc_zero_q  [2];

  logic [7:0]        sd_sum   [2];
  logic [6:0]        sd_curve [2];
  logic signed [7:0] sd_shaped_d [2];
  logic signed [7:0] sd_shaped_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      a_full[i]      = axis_v[i][7] ? 8'(-axis_v[i]) : 8'(axis_v[i]);
      a_mag[i]       = a_full[i][6:0];
      sa_t1_d[i]     = 14'(a_mag[i]) * 14'(AXIS_FULL - expo_eff);
      sa_p_d[i]      = 14'(a_mag[i]) * 14'(a_mag[i]);
      sb_lin_prod[i] = 32'(sa_t1_q[i]) * 32'(RECIP_100);
      sb_lin_sh[i]   = sb_lin_prod[i] >> RECIP_100_SHIFT;
      sc_sq_prod[i]  = 41'(sb_pe_q[i]) * 41'(RECIP_10K);
      sc_sq_sh[i]    = sc_sq_prod[i] >> RECIP_10K_SHIFT;
      sd_sum[i]      = 8'(sc_lin_q[i]) + 8'(sc_sq_q[i]);
      sd_curve[i]    = (sd_sum[i] > 8'(AXIS_FULL)) ? AXIS_FULL : sd_sum[i][6:0];
      if (sc_zero_q[i]) begin
        sd_shaped_d[i] = 8'sd0;
      end else if (sc_neg_q[i]) begin
        sd_shaped_d[i] = -$signed({1'b0, sd_curve[i]});
      end else begin
        sd_shaped_d[i] = $signed({1'b0, sd_curve[i]});
      end
    end
  end

  // Stage registers advance every cycle; the controller waits them out
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      sa_t1_q[i]     <= sa_t1_d[i];
      sa_p_q[i]      <= sa_p_d[i];
      sa_neg_q[i]    <= axis_v[i][7];
      sa_zero_q[i]   <= (a_mag[i] <= deadzone_q);
      sb_lin_q[i]    <= sb_lin_sh[i][6:0];
      sb_pe_q[i]     <= 20'(sa_p_q[i]) * 20'(expo_eff);
      sb_neg_q[i]    <= sa_neg_q[i];
      sb_zero_q[i]   <= sa_zero_q[i];
      sc_lin_q[i]    <= sb_lin_q[i];
      sc_sq_q[i]     <= sc_sq_sh[i][6:0];
      sc_neg_q[i]    <= sb_neg_q[i];
      sc_zero_q[i]   <= sb_zero_q[i];
      sd_shaped_q[i] <= sd_shaped_d[i];
    end
  end

  // Mixer
  logic signed [8:0] mix_l, mix_r;
  logic [7:0]        mag_l, mag_r;
  logic [7:0]        e_lmag_q, e_rmag_q, e_maxa_q;
  logic              e_lneg_q, e_rneg_q;
  logic [DivW-1:0]   e_dividend_q;

  assign mix_l = 9'(sd_shaped_q[1]) + 9'(sd_shaped_q[0]);
  assign mix_r = 9'(sd_shaped_q[1]) - 9'(sd_shaped_q[0]);
  assign mag_l = mix_l[8] ? 8'(-mix_l) : 8'(mix_l);
  assign mag_r = mix_r[8] ? 8'(-mix_r) : 8'(mix_r);

  always_ff @(posedge clk_i) begin
    e_lmag_q     <= mag_l;
    e_rmag_q     <= mag_r;
    e_lneg_q     <= mix_l[8];
    e_rneg_q     <= mix_r[8];
    e_maxa_q     <= (mag_l > mag_r) ? mag_l : mag_r;
    e_dividend_q <= DivW'(lim_eff) * DivW'(AXIS_FULL);
  end

  // Proportional scale: lim*100/maxa when one side exceeds full stick
  logic [DivW-1:0] quotient;
  logic            div_done;
  logic [9:0]      scale;

  ddm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (e_dividend_q),
    .divisor_i  (e_maxa_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign scale = (e_maxa_q > 8'(AXIS_FULL)) ? quotient[9:0] : lim_eff;

  logic [17:0] f_lprod, f_rprod;
  logic [16:0] f_lprod_q, f_rprod_q;
  logic [34:0] g_lprod, g_rprod, g_lsh, g_rsh;
  logic [9:0]  g_lq_q, g_rq_q;

  assign f_lprod = 18'(e_lmag_q) * 18'(scale);
  assign f_rprod = 18'(e_rmag_q) * 18'(scale);
  assign g_lprod = 35'(f_lprod_q) * 35'(RECIP_100);
  assign g_rprod = 35'(f_rprod_q) * 35'(RECIP_100);
  assign g_lsh   = g_lprod >> RECIP_100_SHIFT;
  assign g_rsh   = g_rprod >> RECIP_100_SHIFT;

  always_ff @(posedge clk_i) begin
    f_lprod_q <= f_lprod[16:0];
    f_rprod_q <= f_rprod[16:0];
    g_lq_q    <= g_lsh[9:0];
    g_rq_q    <= g_rsh[9:0];
  end

  // Invert and clamp
  logic [9:0]         lim_l, lim_r;
  logic               neg_l, neg_r;
  logic signed [10:0] drive_l, drive_r;

  assign lim_l   = (g_lq_q > lim_eff) ? lim_eff : g_lq_q;
  assign lim_r   = (g_rq_q > lim_eff) ? lim_eff : g_rq_q;
  assign neg_l   = e_lneg_q ^ inv_left_q;
  assign neg_r   = e_rneg_q ^ inv_right_q;
  assign drive_l = neg_l ? -$signed({1'b0, lim_l}) : $signed({1'b0, lim_l});
  assign drive_r = neg_r ? -$signed({1'b0, lim_r}) : $signed({1'b0, lim_r});

  // Output register
  logic               out_valid_q;
  logic signed [10:0] left_q, right_q;
  logic signed [7:0]  shx_q, shy_q;
  logic               fs_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      left_q   <= drive_l;
      right_q  <= drive_r;
      shx_q    <= sd_shaped_q[0];
      shy_q    <= sd_shaped_q[1];
      fs_out_q <= fs_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign shaped_x_o    = shx_q;
  assign shaped_y_o    = shy_q;
  assign failsafe_o    = fs_out_q;

endmodule

FILE: src/ddm_ctrl.sv
// ----------------------------------------------------------------------------
// ddm_ctrl - controller of the differential drive mixer
// Sequences one update through shaping, division, scaling and output load.
// ----------------------------------------------------------------------------
module ddm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  input  ddm_pkg::ddm_sts_t sts_i,
  output ddm_pkg::ddm_cmd_t cmd_o
);
  import ddm_pkg::*;

  ddm_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i) begin
            cmd_o.check_timeout = 1'b1;
            cnt_d               = 3'd0;
            state_d             = ST_SHAPE;
          end else begin
            cmd_o.store_cmd = 1'b1;
          end
        end
      end
      ST_SHAPE: begin
        if (cnt_q == SHAPE_CYCLES - 3'd1) begin
          state_d = ST_DIV_START;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (sts_i.div_done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: dv/tb_differential_drive_mixer_unit.sv
// ----------------------------------------------------------------------------
// tb_differential_drive_mixer_unit - self-checking bench of the drive mixer
// Drives stick command and update requests on the slave stream. Each update
// result is predicted by a behavioural model of the mixer or typed in the
// table; master stream results are compared field by field with it. A short
// directed table comes first, then random phases under several register
// settings, with both stream sides idling at random except in the last third.
// ----------------------------------------------------------------------------
module tb_differential_drive_mixer_unit;
  import ddm_pkg::*;

  localparam logic MODE_STICK  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;
  // Index beyond the register list; the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE = 3'd6;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 105;

  typedef struct packed {
    logic        mode;
    logic [15:0] stick_x;
    logic [15:0] stick_y;
    logic [31:0] now_ms;
  } stick_req_t;

  // Field order matches m_axis_tdata from bit 0 upwards (last member lowest)
  typedef struct packed {
    logic               failsafe;
    logic signed [7:0]  shaped_y;
    logic signed [7:0]  shaped_x;
    logic signed [10:0] right_drive;
    logic signed [10:0] left_drive;
  } drive_res_t;

  typedef struct {
    stick_req_t req;
    bit         typed;
    drive_res_t res;
  } table_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata  = '0;  // stick_x[15:0], stick_y[31:16], now_ms[63:32]
  logic                s_axis_tuser  = 1'b0; // mode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;        // left_drive[10:0], right_drive[21:11],
                                            // shaped_x[29:22], shaped_y[37:30],
                                            // failsafe[38], zero pad[39]

  differential_drive_mixer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the register file and of the mixer state
  logic [6:0]  deadzone_r  = DEADZONE_RST;
  logic [6:0]  expo_r      = EXPO_RST;
  logic [9:0]  max_pm_r    = MAX_PERMILLE_RST;
  logic [15:0] timeout_r   = TIMEOUT_RST;
  logic        inv_left_r  = 1'b0;
  logic        inv_right_r = 1'b0;
  int          held_x      = 0;
  int          held_y      = 0;
  logic [31:0] last_cmd_ms = '0;
  logic        failsafe_r  = 1'b1;

  drive_res_t pending_drive[$];
  table_row_t directed_rows[$];
  int         fault_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  int         quiet_cycles   = 0;
  logic [31:0] clock_ms      = '0;

  function automatic int clamp_sym(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Deadzone, then the blend of linear and squared response, capped at full
  function automatic int curve_axis(input int v);
    int a, e, s;
    a = (v < 0) ? -v : v;
    e = (expo_r > 7'd100) ? 100 : int'(expo_r);
    if (a <= int'(deadzone_r)) return 0;
    if (e == 0) return v;
    s = a * (100 - e) / 100 + a * a * e / 10000;
    if (s > 100) s = 100;
    return (v < 0) ? -s : s;
  endfunction

  task automatic mix_predict(input stick_req_t r, output bit has, output drive_res_t res);
    int x, y, l, rt, la, ra, maxa, scale, lim;
    logic [31:0] age;
    has = 1'b0;
    res = '0;
    if (r.mode == MODE_STICK) begin
      held_x      = clamp_sym(int'($signed(r.stick_x)), 100);
      held_y      = clamp_sym(int'($signed(r.stick_y)), 100);
      last_cmd_ms = r.now_ms;
    end else begin
      age = r.now_ms - last_cmd_ms;
      if (age > {16'd0, timeout_r}) begin
        held_x     = 0;
        held_y     = 0;
        failsafe_r = 1'b1;
      end else begin
        failsafe_r = 1'b0;
      end
      x   = curve_axis(held_x);
      y   = curve_axis(held_y);
      lim = (max_pm_r > 10'd1000) ? 1000 : int'(max_pm_r);
      l   = 0;
      rt  = 0;
      if (x != 0 || y != 0) begin
        l     = y + x;
        rt    = y - x;
        la    = (l < 0) ? -l : l;
        ra    = (rt < 0) ? -rt : rt;
        maxa  = (la > ra) ? la : ra;
        scale = lim;
        if (maxa > 100) scale = scale * 100 / maxa;
        l  = l * scale / 100;
        rt = rt * scale / 100;
        if (inv_left_r) l = -l;
        if (inv_right_r) rt = -rt;
        l  = clamp_sym(l, lim);
        rt = clamp_sym(rt, lim);
      end
      res.left_drive  = 11'(l);
      res.right_drive = 11'(rt);
      res.shaped_x    = 8'(x);
      res.shaped_y    = 8'(y);
      res.failsafe    = failsafe_r;
      has = 1'b1;
    end
  endtask

  // Write one register at the coming rising edge; keep the shadow in step
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CFG_DEADZONE:     deadzone_r  = val[6:0];
      CFG_EXPO_PERCENT: expo_r      = val[6:0];
      CFG_MAX_PERMILLE: max_pm_r    = val[9:0];
      CFG_TIMEOUT_MS:   timeout_r   = val;
      CFG_INVERT_LEFT:  inv_left_r  = val[0];
      CFG_INVERT_RIGHT: inv_right_r = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_regs(input int dz, input int expo, input int max_pm, input int tmo,
                          input int inv_l, input int inv_r);
    write_reg(CFG_DEADZONE, 16'(dz));
    write_reg(CFG_EXPO_PERCENT, 16'(expo));
    write_reg(CFG_MAX_PERMILLE, 16'(max_pm));
    write_reg(CFG_TIMEOUT_MS, 16'(tmo));
    write_reg(CFG_INVERT_LEFT, 16'(inv_l));
    write_reg(CFG_INVERT_RIGHT, 16'(inv_r));
    cfg_we_i = 1'b0;
  endtask

  // Present one request from a falling edge, hold it until taken, and log the
  // drive result it should produce. A typed row overrides the model.
  task automatic send_request(input stick_req_t r, input bit typed, input drive_res_t typed_res);
    bit         has;
    drive_res_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = r.mode;
    s_axis_tdata  = {r.now_ms, r.stick_y, r.stick_x};
    do @(posedge clk_i); while (!s_axis_tready);
    mix_predict(r, has, res);
    if (has) pending_drive.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic mode, input int x, input int y, input logic [31:0] now,
                         input bit typed, input int l, input int rt, input int sx,
                         input int sy, input logic fs);
    table_row_t row;
    row.req.mode            = mode;
    row.req.stick_x         = 16'(x);
    row.req.stick_y         = 16'(y);
    row.req.now_ms          = now;
    row.typed               = typed;
    row.res.left_drive      = 11'(l);
    row.res.right_drive     = 11'(rt);
    row.res.shaped_x        = 8'(sx);
    row.res.shaped_y        = 8'(sy);
    row.res.failsafe        = fs;
    directed_rows.push_back(row);
  endtask

  // Reset register values throughout: deadzone 5, linear, full scale, 200 ms
  task automatic build_directed();
    add_row(MODE_UPDATE, 0, 0, 32'd0, 1, 0, 0, 0, 0, 0);            // fresh, no timeout yet
    add_row(MODE_UPDATE, 0, 0, 32'd201, 1, 0, 0, 0, 0, 1);          // one past timeout
    add_row(MODE_STICK, 32767, 0, 32'd300, 0, 0, 0, 0, 0, 0);       // clamp positive extreme
    add_row(MODE_UPDATE, 0, 0, 32'd300, 1, 1000, -1000, 100, 0, 0); // pure spin
    add_row(MODE_STICK, -32768, -32768, 32'd400, 0, 0, 0, 0, 0, 0); // clamp negative extreme
    add_row(MODE_UPDATE, 0, 0, 32'd400, 1, -1000, 0, -100, -100, 0); // scaled back by half
    add_row(MODE_STICK, 5, -5, 32'd500, 0, 0, 0, 0, 0, 0);          // on the deadzone edge
    add_row(MODE_UPDATE, 0, 0, 32'd500, 1, 0, 0, 0, 0, 0);          // both axes zero
    add_row(MODE_STICK, 6, 0, 32'd600, 0, 0, 0, 0, 0, 0);           // just past deadzone
    add_row(MODE_UPDATE, 0, 0, 32'd600, 1, 60, -60, 6, 0, 0);
    add_row(MODE_STICK, 1000, -101, 32'd700, 0, 0, 0, 0, 0, 0);     // clamp just beyond
    add_row(MODE_UPDATE, 0, 0, 32'd700, 1, 0, -1000, 100, -100, 0);
    add_row(MODE_STICK, 50, 50, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0);   // age wraps, in time
    add_row(MODE_UPDATE, 0, 0, 32'h0000_0050, 1, 1000, 0, 50, 50, 0);
    add_row(MODE_STICK, 30, -20, 32'd1000, 0, 0, 0, 0, 0, 0);
    add_row(MODE_UPDATE, 0, 0, 32'd1200, 1, 100, -500, 30, -20, 0); // age equals timeout
    add_row(MODE_UPDATE, 0, 0, 32'd1201, 1, 0, 0, 0, 0, 1);         // trips, clears stick
    add_row(MODE_UPDATE, 0, 0, 32'd1202, 1, 0, 0, 0, 0, 1);         // held values stay zero
    add_row(MODE_STICK, -100, 100, 32'd1300, 0, 0, 0, 0, 0, 0);
    add_row(MODE_UPDATE, 0, 0, 32'd1300, 1, 0, 1000, -100, 100, 0);
    add_row(MODE_UPDATE, -1, -1, 32'd1301, 0, 0, 0, 0, 0, 0);       // stick bits ignored
    add_row(MODE_STICK, 10, 10, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0);   // age wraps, too old
    add_row(MODE_UPDATE, 0, 0, 32'h0000_0010, 1, 0, 0, 0, 0, 1);
  endtask

  // Axis value: mostly near the clamp range, some full-width, some on the deadzone
  function automatic logic [15:0] pick_axis();
    int k, v;
    k = $urandom_range(0, 9);
    if (k <= 5) begin
      v = int'($urandom_range(0, 220)) - 110;
    end else if (k <= 7) begin
      v = int'($urandom() & 32'hFFFF);
    end else if (k == 8) begin
      v = int'(deadzone_r) + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      case ($urandom_range(0, 6))
        0: v = -32768;
        1: v = 32767;
        2: v = 100;
        3: v = -100;
        4: v = 101;
        5: v = -101;
        default: v = 0;
      endcase
    end
    return 16'(v);
  endfunction

  // Commands and updates over a clock that mostly stays within the timeout,
  // sometimes lands on its edge and now and then jumps anywhere
  task automatic run_random(input int count);
    stick_req_t r;
    drive_res_t none;
    int         t;
    none     = '0;
    clock_ms = $urandom();
    repeat (count) begin
      t = int'(timeout_r);
      case ($urandom_range(0, 19))
        0:       clock_ms = $urandom();
        1:       clock_ms = clock_ms + 32'(t + 1);
        2:       clock_ms = clock_ms + 32'(t);
        3, 4, 5: clock_ms = clock_ms + 32'($urandom_range(0, t * 2 + 2));
        default: clock_ms = clock_ms + 32'($urandom_range(0, t / 4 + 1));
      endcase
      r.mode    = ($urandom_range(0, 99) < 40) ? MODE_STICK : MODE_UPDATE;
      r.stick_x = pick_axis();
      r.stick_y = pick_axis();
      r.now_ms  = clock_ms;
      send_request(r, 1'b0, none);
    end
  endtask

  // Hold off until every result is in and the pipeline has gone quiet
  task automatic drain_and_settle();
    s_axis_tvalid = 1'b0;
    while (pending_drive.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_phase(input int p);
    case (p)
      0: set_regs(0, 0, 1000, 200, 0, 0);
      1: set_regs(127, 100, 1000, 65535, 1, 0);  // deadzone swallows the whole stick
      2: set_regs(5, 127, 1023, 0, 0, 1);        // expo and scale above range
      3: set_regs(20, 50, 0, 500, 1, 1);         // zero full scale
      4: set_regs(3, 37, 731, 1000, 0, 1);
      5: set_regs(100, 1, 1, 65535, 1, 1);
      6: set_regs(8, 64, 512, 50, 0, 0);
      7: set_regs(1, 99, 999, 300, 1, 0);
      default: set_regs($urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 1023), $urandom_range(0, 65535),
                        $urandom_range(0, 1), $urandom_range(0, 1));
    endcase
    if (p == 3) begin
      write_reg(CFG_IDX_SPARE, 16'($urandom()));
      cfg_we_i = 1'b0;
    end
  endtask

  // Receiver: drop tready at random for the current idle share
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_fault(input string what, input drive_res_t want, input drive_res_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected L=%0d R=%0d X=%0d Y=%0d FS=%0d, got L=%0d R=%0d X=%0d Y=%0d FS=%0d",
               what, want.left_drive, want.right_drive, want.shaped_x, want.shaped_y,
               want.failsafe, got.left_drive, got.right_drive, got.shaped_x, got.shaped_y,
               got.failsafe);
    end
  endtask

  // Compare every accepted result with the oldest outstanding prediction
  always @(posedge clk_i) begin : result_check
    drive_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = drive_res_t'(m_axis_tdata[38:0]);
      if (pending_drive.size() == 0) begin
        want = '0;
        report_fault("unexpected result", want, got);
      end else begin
        want = pending_drive.pop_front();
        if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
            got.shaped_x !== want.shaped_x || got.shaped_y !== want.shaped_y ||
            got.failsafe !== want.failsafe) begin
          report_fault("result mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: give up when no request or result moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_differential_drive_mixer_unit NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table under reset settings, sender 36 % idle, receiver 67 %
    send_idle_pct = 36;
    recv_idle_pct = 67;
    build_directed();
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases: swap the idle shares after a third, stop idling after two
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      if (p < PHASES / 3) begin
        send_idle_pct = 36;
        recv_idle_pct = 67;
      end else if (p < 2 * PHASES / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_phase(p);
      run_random(PHASE_ITEMS);
    end

    s_axis_tvalid = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && pending_drive.size() == 0) begin
      $display("tb_differential_drive_mixer_unit OK");
    end else begin
      $display("tb_differential_drive_mixer_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: differential_drive_mixer_unit.f
src/ddm_pkg.sv
src/ddm_div.sv
src/ddm_dp.sv
src/ddm_ctrl.sv
src/differential_drive_mixer_unit.sv
dv/tb_differential_drive_mixer_unit.sv
